// ===== hw/rtl/encoder_speed_estimator_top_defines.svh =====
// Assertion helpers for the encoder speed estimator.
// Each check samples on clk and is off while arst_n is low.
`ifndef ENCODER_SPEED_ESTIMATOR_TOP_DEFINES_SVH
`define ENCODER_SPEED_ESTIMATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ESP_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("esp check failed");
`define ESP_IMPLY(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("esp check failed");
`else
`define ESP_NEVER(label, cond)
`define ESP_IMPLY(label, pre, post)
`endif
`endif

// ===== hw/rtl/esp_pkg.sv =====
package esp_pkg;

	localparam int BATCH_SIZE_DEF   = 10;
	localparam int COUNTER_BITS_DEF = 16;

	// shared divider: dividend and divisor widths
	localparam int DIV_NW = 64;
	localparam int DIV_DW = 26;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 17;
	localparam int TDATA_IN_W  = 24;
	localparam int TDATA_OUT_W = 256;

	typedef enum logic [CFG_IW-1:0] {
		CFG_PERIOD = 3'd0,
		CFG_CPR    = 3'd1,
		CFG_RATIO  = 3'd2,
		CFG_GLITCH = 3'd3,
		CFG_COEFF  = 3'd4
	} cfg_idx_t;

	localparam logic [7:0]  PERIOD_RST = 8'd50;
	localparam logic [15:0] CPR_RST    = 16'd2000;
	localparam logic [9:0]  RATIO_RST  = 10'd30;
	localparam logic [15:0] GLITCH_RST = 16'd60000;
	localparam logic [16:0] COEFF_RST  = 17'd58982;
	localparam logic [16:0] Q_ONE      = 17'd65536;

	localparam logic CMD_OVF  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_DELTA,
		OP_SMUL,
		OP_SPEED,
		OP_AVG,
		OP_F1,
		OP_F2,
		OP_F3,
		OP_DMUL,
		OP_LOAD
	} op_t;

	typedef enum logic [2:0] {
		DS_K,
		DS_SPD,
		DS_AVG,
		DS_SS,
		DS_SP,
		DS_RT,
		DS_ST
	} dsel_t;

	typedef struct packed {
		op_t   op;
		logic  div_start;
		dsel_t div_sel;
	} esp_cmd_t;

	typedef struct packed {
		logic tick_hit;
		logic batch_full;
		logic div_busy;
		logic div_done;
	} esp_sts_t;

endpackage

// ===== hw/rtl/esp_div.sv =====
module esp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [esp_pkg::DIV_NW-1:0] dividend,
	input  logic [esp_pkg::DIV_DW-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [esp_pkg::DIV_NW-1:0] quotient
);
	import esp_pkg::*;

	localparam int CW = $clog2(DIV_NW + 1);

	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW:0]   trial;
	logic              fits;
	logic [DIV_DW:0]   diff;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(DIV_NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= cnt_q == CW'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_NW-2:0], fits};
			rem_q <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
		end
	end

	assign busy     = cnt_q != '0;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/esp_dp.sv =====
module esp_dp #(
	parameter int BATCH_SIZE   = esp_pkg::BATCH_SIZE_DEF,
	parameter int COUNTER_BITS = esp_pkg::COUNTER_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  esp_pkg::esp_cmd_t          cmd,
	output esp_pkg::esp_sts_t          sts,
	input  logic                       in_accept,
	input  logic                       in_cmd,
	input  logic                       in_count_down,
	input  logic [15:0]                in_counter_value,
	input  logic                       cfg_we,
	input  logic [esp_pkg::CFG_IW-1:0] cfg_index,
	input  logic [esp_pkg::CFG_DW-1:0] cfg_data,
	output logic [31:0]                motor_rpm,
	output logic [31:0]                shaft_speed,
	output logic [47:0]                motor_count,
	output logic [47:0]                shaft_position,
	output logic [47:0]                rotor_turns,
	output logic [47:0]                shaft_turns
);
	import esp_pkg::*;

	localparam int FW = $clog2(BATCH_SIZE);
	localparam int SW = 33 + $clog2(BATCH_SIZE);
	localparam int MW = SW + 2;
	localparam logic [FW-1:0]     FILL_LAST = FW'(BATCH_SIZE - 1);
	localparam logic [63:0]       CNT_MASK  = (64'd1 << COUNTER_BITS) - 64'd1;

	// divide by the trimmed count: long division in byte digits, each digit
	// by reciprocal multiplication
	localparam int CD_D  = BATCH_SIZE - 4;
	localparam int CD_W  = 8;
	localparam int CD_RW = 5;
	localparam int CD_XW = CD_RW + CD_W;
	localparam int CD_S  = CD_XW + CD_RW;
	localparam int CD_MW = CD_S + 1;
	localparam int CD_N  = (MW + CD_W - 1) / CD_W;
	localparam int CD_NW = CD_N * CD_W;
	localparam int CCW   = $clog2(CD_N + 1);
	localparam logic [CD_MW-1:0] CD_M =
		CD_MW'(((64'd1 << CD_S) + 64'(CD_D - 1)) / 64'(CD_D));

	// config
	logic [7:0]  period_q;
	logic [15:0] cpr_q;
	logic [9:0]  ratio_q;
	logic [15:0] glitch_q;
	logic [16:0] coeff_q;

	// running state
	logic [31:0] ovf_q;
	logic [7:0]  tick_q;
	logic [31:0] prev_q;
	logic [47:0] pos_q;
	logic [FW-1:0] fill_q;
	logic signed [31:0] fs_q;

	// work registers
	logic [31:0] total_q;
	logic [15:0] mag_q;
	logic        neg_q;
	logic [15:0] k_q;
	logic [31:0] prod_q;
	logic signed [31:0] spd_q;
	logic signed [SW-1:0] sum_q;
	logic signed [31:0] lo1_q, lo2_q, hi1_q, hi2_q;
	logic        mid_neg_q;
	logic [MW-1:0] mid_mag_q;
	logic signed [31:0] avg_q;
	logic signed [50:0] acc_q;
	logic [DIV_DW-1:0] cprr_q;
	logic [47:0] pmag_q;
	logic        pneg_q;
	logic [31:0] ss_q;
	logic [47:0] sp_q, rt_q;

	logic [31:0] rs_o_q, ss_o_q;
	logic [47:0] rp_o_q, sp_o_q, rt_o_q, st_o_q;

	// constant divider
	logic [CCW-1:0]   ccnt_q;
	logic             cdone_q;
	logic [CD_NW-1:0] cq_q;
	logic [CD_RW-1:0] crem_q;
	logic             cdiv_start;
	logic [CD_XW-1:0] cx;
	logic [31:0]      cprod;
	logic [CD_W-1:0]  cdig;
	logic [CD_XW-1:0] cback;
	logic [CD_XW-1:0] cdiff;

	logic [63:0] ovf_shift;
	logic [31:0] total;
	logic        tick_hit;
	logic [8:0]  period_eff;
	logic [15:0] cpr_eff;
	logic [9:0]  ratio_eff;
	logic [31:0] delta, dmag;
	logic        dneg, keep;
	logic signed [MW-1:0] mid;
	logic [16:0] q_eff;
	logic signed [17:0] q_s, w_s;
	logic signed [50:0] acc_adj;
	logic [31:0] fs_mag;
	logic [DIV_NW-1:0] div_a;
	logic [DIV_DW-1:0] div_b;
	logic [DIV_NW-1:0] quo;
	logic        gdiv_start;
	logic        div_busy, div_done;
	logic signed [31:0] spd_sat;
	logic [47:0] q16_signed;

	assign ovf_shift = {32'd0, ovf_q} << COUNTER_BITS;
	assign total     = (32'(in_counter_value) & CNT_MASK[31:0]) + ovf_shift[31:0];
	assign tick_hit  = tick_q == period_q;

	assign period_eff = (period_q == 8'd0) ? 9'd256 : {1'b0, period_q};
	assign cpr_eff    = (cpr_q == 16'd0) ? 16'd1 : cpr_q;
	assign ratio_eff  = (ratio_q == 10'd0) ? 10'd1 : ratio_q;

	assign delta = total_q - prev_q;
	assign dneg  = delta[31];
	assign dmag  = dneg ? (32'd0 - delta) : delta;
	assign keep  = dmag < {16'd0, glitch_q};

	// trimmed sum: drop the two lowest and the two highest
	assign mid = MW'(sum_q) - MW'(lo1_q) - MW'(lo2_q) - MW'(hi1_q) - MW'(hi2_q);

	assign q_eff   = (coeff_q > Q_ONE) ? Q_ONE : coeff_q;
	assign q_s     = signed'({1'b0, q_eff});
	assign w_s     = signed'({1'b0, Q_ONE - q_eff});
	assign acc_adj = acc_q[50] ? (acc_q + 51'sd65535) : acc_q;
	assign fs_mag  = fs_q[31] ? (32'd0 - fs_q) : fs_q;

	always_comb begin
		div_a = 64'd1000;
		div_b = DIV_DW'(period_eff);
		case (cmd.div_sel)
			DS_K: begin
				div_a = 64'd1000;
				div_b = DIV_DW'(period_eff);
			end
			DS_SPD: begin
				div_a = {16'd0, prod_q, 16'd0};
				div_b = DIV_DW'(cpr_eff);
			end
			DS_SS: begin
				div_a = DIV_NW'(fs_mag);
				div_b = DIV_DW'(ratio_eff);
			end
			DS_SP: begin
				div_a = {pmag_q, 16'd0};
				div_b = DIV_DW'(ratio_eff);
			end
			DS_RT: begin
				div_a = {pmag_q, 16'd0};
				div_b = DIV_DW'(cpr_eff);
			end
			DS_ST: begin
				div_a = {pmag_q, 16'd0};
				div_b = cprr_q;
			end
			default: begin
				div_a = 64'd1000;
				div_b = DIV_DW'(period_eff);
			end
		endcase
	end

	assign cdiv_start = cmd.div_start && (cmd.div_sel == DS_AVG);
	assign gdiv_start = cmd.div_start && (cmd.div_sel != DS_AVG);

	esp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (gdiv_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	// one quotient digit per cycle, remainder stays below the divisor
	assign cx    = {crem_q, cq_q[CD_NW-1 -: CD_W]};
	assign cprod = 32'(cx) * 32'(CD_M);
	assign cdig  = cprod[CD_S +: CD_W];
	assign cback = CD_XW'(cdig) * CD_XW'(CD_D);
	assign cdiff = cx - cback;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccnt_q  <= '0;
			cdone_q <= 1'b0;
		end else if (cdiv_start) begin
			ccnt_q  <= CCW'(CD_N);
			cdone_q <= 1'b0;
		end else if (ccnt_q != '0) begin
			ccnt_q  <= ccnt_q - CCW'(1);
			cdone_q <= ccnt_q == CCW'(1);
		end else begin
			cdone_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cdiv_start) begin
			cq_q   <= CD_NW'(mid_mag_q);
			crem_q <= '0;
		end else if (ccnt_q != '0) begin
			cq_q   <= {cq_q[CD_NW-CD_W-1:0], cdig};
			crem_q <= cdiff[CD_RW-1:0];
		end
	end

	always_comb begin
		if (neg_q)
			spd_sat = (quo >= 64'h8000_0000) ? S32_MIN : signed'(32'd0 - quo[31:0]);
		else
			spd_sat = (quo > 64'h7FFF_FFFF) ? S32_MAX : signed'(quo[31:0]);
	end

	assign q16_signed = pneg_q ? (48'd0 - quo[47:0]) : quo[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			cpr_q    <= CPR_RST;
			ratio_q  <= RATIO_RST;
			glitch_q <= GLITCH_RST;
			coeff_q  <= COEFF_RST;
			ovf_q    <= '0;
			tick_q   <= '0;
			prev_q   <= '0;
			pos_q    <= '0;
			fill_q   <= '0;
			fs_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PERIOD: period_q <= cfg_data[7:0];
					CFG_CPR:    cpr_q    <= cfg_data[15:0];
					CFG_RATIO:  ratio_q  <= cfg_data[9:0];
					CFG_GLITCH: glitch_q <= cfg_data[15:0];
					CFG_COEFF:  coeff_q  <= cfg_data[16:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_ACCEPT: begin
					if (in_accept) begin
						if (in_cmd == CMD_TICK)
							tick_q <= tick_hit ? 8'd1 : tick_q + 8'd1;
						else if (in_count_down)
							ovf_q <= ovf_q - 32'd1;
						else
							ovf_q <= ovf_q + 32'd1;
					end
				end
				OP_DELTA: begin
					prev_q <= total_q;
					if (keep)
						pos_q <= pos_q + {{16{delta[31]}}, delta};
				end
				OP_SPEED: fill_q <= (fill_q == FILL_LAST) ? '0 : fill_q + FW'(1);
				OP_F3:    fs_q   <= acc_adj[47:16];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCEPT && in_accept && in_cmd == CMD_TICK && tick_hit)
			total_q <= total;
		case (cmd.op)
			OP_DELTA: begin
				mag_q <= keep ? dmag[15:0] : 16'd0;
				neg_q <= keep & dneg;
			end
			OP_SMUL: prod_q <= 32'(mag_q) * 32'(k_q);
			OP_SPEED: begin
				if (fill_q == '0) begin
					sum_q <= SW'(spd_q);
					lo1_q <= spd_q;
					lo2_q <= S32_MAX;
					hi1_q <= spd_q;
					hi2_q <= S32_MIN;
				end else begin
					sum_q <= sum_q + SW'(spd_q);
					if (spd_q < lo1_q) begin
						lo2_q <= lo1_q;
						lo1_q <= spd_q;
					end else if (spd_q < lo2_q) begin
						lo2_q <= spd_q;
					end
					if (spd_q > hi1_q) begin
						hi2_q <= hi1_q;
						hi1_q <= spd_q;
					end else if (spd_q > hi2_q) begin
						hi2_q <= spd_q;
					end
				end
			end
			OP_AVG: begin
				mid_neg_q <= mid[MW-1];
				mid_mag_q <= mid[MW-1] ? MW'(-mid) : MW'(mid);
			end
			OP_F1: acc_q <= 51'(q_s) * 51'(avg_q);
			OP_F2: acc_q <= acc_q + 51'(w_s) * 51'(fs_q);
			OP_DMUL: begin
				cprr_q <= DIV_DW'(cpr_eff) * DIV_DW'(ratio_eff);
				pneg_q <= pos_q[47];
				pmag_q <= pos_q[47] ? (48'd0 - pos_q) : pos_q;
			end
			OP_LOAD: begin
				rs_o_q <= fs_q;
				ss_o_q <= ss_q;
				rp_o_q <= pos_q;
				sp_o_q <= sp_q;
				rt_o_q <= rt_q;
				st_o_q <= q16_signed;
			end
			default: ;
		endcase
		if (cdone_q)
			avg_q <= mid_neg_q ? signed'(32'd0 - cq_q[31:0]) : signed'(cq_q[31:0]);
		if (div_done) begin
			case (cmd.div_sel)
				DS_K:   k_q   <= 16'(quo[9:0]) * 16'd60;
				DS_SPD: spd_q <= spd_sat;
				DS_SS:  ss_q  <= fs_q[31] ? (32'd0 - quo[31:0]) : quo[31:0];
				DS_SP:  sp_q  <= q16_signed;
				DS_RT:  rt_q  <= q16_signed;
				default: ;
			endcase
		end
	end

	assign sts.tick_hit   = tick_hit;
	assign sts.batch_full = fill_q == FILL_LAST;
	assign sts.div_busy   = div_busy | (ccnt_q != '0);
	assign sts.div_done   = div_done | cdone_q;

	assign motor_rpm      = rs_o_q;
	assign shaft_speed    = ss_o_q;
	assign motor_count    = rp_o_q;
	assign shaft_position = sp_o_q;
	assign rotor_turns    = rt_o_q;
	assign shaft_turns    = st_o_q;

endmodule

// ===== hw/rtl/esp_ctrl.sv =====
module esp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_cmd,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  esp_pkg::esp_sts_t sts,
	output esp_pkg::esp_cmd_t cmd
);
	import esp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DELTA, S_KDIV, S_KWAIT, S_SMUL, S_SDIV, S_SWAIT, S_SPEED,
		S_AVG, S_ADIV, S_AWAIT, S_F1, S_F2, S_F3, S_DMUL,
		S_SSDIV, S_SSWAIT, S_SPDIV, S_SPWAIT, S_RTDIV, S_RTWAIT,
		S_STDIV, S_STWAIT, S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   load_ok;

	assign load_ok   = !out_valid_q || out_ready;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op        = OP_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel   = DS_K;
		case (state_q)
			S_IDLE:   cmd.op = OP_ACCEPT;
			S_DELTA:  cmd.op = OP_DELTA;
			S_KDIV:   cmd.div_start = 1'b1;
			S_KWAIT:  cmd.div_sel = DS_K;
			S_SMUL:   cmd.op = OP_SMUL;
			S_SDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_SPD;
			end
			S_SWAIT:  cmd.div_sel = DS_SPD;
			S_SPEED:  cmd.op = OP_SPEED;
			S_AVG:    cmd.op = OP_AVG;
			S_ADIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_AVG;
			end
			S_AWAIT:  cmd.div_sel = DS_AVG;
			S_F1:     cmd.op = OP_F1;
			S_F2:     cmd.op = OP_F2;
			S_F3:     cmd.op = OP_F3;
			S_DMUL:   cmd.op = OP_DMUL;
			S_SSDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_SS;
			end
			S_SSWAIT: cmd.div_sel = DS_SS;
			S_SPDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_SP;
			end
			S_SPWAIT: cmd.div_sel = DS_SP;
			S_RTDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_RT;
			end
			S_RTWAIT: cmd.div_sel = DS_RT;
			S_STDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_ST;
			end
			S_STWAIT: cmd.div_sel = DS_ST;
			S_OUT: begin
				cmd.div_sel = DS_ST;
				if (load_ok)
					cmd.op = OP_LOAD;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && load_ok)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_cmd == CMD_TICK && sts.tick_hit)
						state_q <= S_DELTA;
				end
				S_DELTA:  state_q <= S_KDIV;
				S_KDIV:   state_q <= S_KWAIT;
				S_KWAIT:  if (sts.div_done) state_q <= S_SMUL;
				S_SMUL:   state_q <= S_SDIV;
				S_SDIV:   state_q <= S_SWAIT;
				S_SWAIT:  if (sts.div_done) state_q <= S_SPEED;
				S_SPEED:  state_q <= sts.batch_full ? S_AVG : S_IDLE;
				S_AVG:    state_q <= S_ADIV;
				S_ADIV:   state_q <= S_AWAIT;
				S_AWAIT:  if (sts.div_done) state_q <= S_F1;
				S_F1:     state_q <= S_F2;
				S_F2:     state_q <= S_F3;
				S_F3:     state_q <= S_DMUL;
				S_DMUL:   state_q <= S_SSDIV;
				S_SSDIV:  state_q <= S_SSWAIT;
				S_SSWAIT: if (sts.div_done) state_q <= S_SPDIV;
				S_SPDIV:  state_q <= S_SPWAIT;
				S_SPWAIT: if (sts.div_done) state_q <= S_RTDIV;
				S_RTDIV:  state_q <= S_RTWAIT;
				S_RTWAIT: if (sts.div_done) state_q <= S_STDIV;
				S_STDIV:  state_q <= S_STWAIT;
				S_STWAIT: if (sts.div_done) state_q <= S_OUT;
				S_OUT:    if (load_ok) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/encoder_speed_estimator_top.sv =====
// Encoder speed estimator.
// s_axis: one beat per event. tuser = 0 is a counter overflow (tdata[0] = 1
// counts down), tuser = 1 is a sample tick carrying the counter in tdata[16:1].
// cfg: register writes (index 0..4: period, counts/rev, ratio, glitch limit,
// filter weight), always ready, to be used only while the block is idle.
// m_axis: one 256-bit beat per finished batch of speeds with filtered speed,
// shaft speed, position and turns.
// Flow: overflow beats and ticks that do not end a sample period are taken
// in the idle state. A period-ending tick runs two passes of the shared
// radix-2 divider before s_axis_tready comes back. A batch-ending tick adds
// a divide by the trimmed batch count, the filter and four more divider
// passes; m_axis_tvalid rises as the result is loaded, and s_axis_tready
// returns in that same cycle. s_axis_tready is low for the whole
// computation, while the state machine steps through the dividers.
// Reset (arst_n low) clears counts, position, filter state and loads the
// default registers. A stalled m_axis holds its beat; the next batch result
// waits in the controller, and input is taken again once it is loaded.
`include "encoder_speed_estimator_top_defines.svh"

module encoder_speed_estimator_top #(
	parameter int BATCH_SIZE   = esp_pkg::BATCH_SIZE_DEF,
	parameter int COUNTER_BITS = esp_pkg::COUNTER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [0] count_down, [16:1] counter_value, [23:17] zero
	input  logic [esp_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
	// [0] cmd
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [31:0] motor_rpm, [63:32] shaft_speed, [111:64] motor_count,
	// [159:112] shaft_position, [207:160] rotor_turns, [255:208] shaft_turns
	output logic [esp_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [esp_pkg::CFG_IW-1:0]      cfg_index,
	input  logic [esp_pkg::CFG_DW-1:0]      cfg_data
);
	import esp_pkg::*;

	esp_cmd_t dp_cmd;
	esp_sts_t dp_sts;
	logic     in_accept;
	logic [31:0] motor_rpm, shaft_speed;
	logic [47:0] motor_count, shaft_position, rotor_turns, shaft_turns;

	assign in_accept = s_axis_tvalid & s_axis_tready;
	assign cfg_ready = 1'b1;

	esp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	esp_dp #(
		.BATCH_SIZE   (BATCH_SIZE),
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (dp_cmd),
		.sts              (dp_sts),
		.in_accept        (in_accept),
		.in_cmd           (s_axis_tuser),
		.in_count_down    (s_axis_tdata[0]),
		.in_counter_value (s_axis_tdata[16:1]),
		.cfg_we           (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.motor_rpm        (motor_rpm),
		.shaft_speed      (shaft_speed),
		.motor_count      (motor_count),
		.shaft_position   (shaft_position),
		.rotor_turns      (rotor_turns),
		.shaft_turns      (shaft_turns)
	);

	assign m_axis_tdata = {shaft_turns, rotor_turns, shaft_position, motor_count,
		shaft_speed, motor_rpm};

	// divider is never restarted mid-pass
	`ESP_NEVER(a_div_overlap, dp_cmd.div_start && dp_sts.div_busy)
	// no input taken while a division runs
	`ESP_IMPLY(a_busy_no_input, dp_sts.div_busy, !s_axis_tready)
	// a result only enters a free or draining output register
	`ESP_IMPLY(a_load_free, dp_cmd.op == OP_LOAD, !m_axis_tvalid || m_axis_tready)

endmodule

// ===== tb/encoder_speed_estimator_checker.sv =====
`timescale 1ns / 100ps

module encoder_speed_estimator_checker
	import esp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	input  logic                    s_axis_tready,
	input  logic [TDATA_IN_W-1:0]   s_axis_tdata,
	input  logic                    s_axis_tuser,
	input  logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	input  logic [TDATA_OUT_W-1:0]  m_axis_tdata,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IW-1:0]       cfg_index,
	input  logic [CFG_DW-1:0]       cfg_data,
	output int                      fail_count,
	output int                      pending
);

	typedef struct {
		bit [31:0] motor_rpm;
		bit [31:0] shaft_speed;
		bit [47:0] rotor_pos;
		bit [47:0] shaft_pos;
		bit [47:0] rotor_turns;
		bit [47:0] shaft_turns;
	} speed_report_t;

	speed_report_t report_q[$];

	// register copies
	bit [7:0]  period_r;
	bit [15:0] cpr_r;
	bit [9:0]  ratio_r;
	bit [15:0] glitch_r;
	bit [16:0] coeff_r;

	// predictor state
	bit [31:0] ovf_cnt;
	bit [7:0]  tick_cnt;
	bit [31:0] last_total;
	bit [47:0] pos_sum;
	int        speeds[BATCH_SIZE_DEF];
	int        fill;
	int        filt;

	function automatic bit [47:0] q16_quot(longint v, longint unsigned d);
		longint unsigned mag, q;
		mag = (v < 0) ? longint'(-v) : longint'(v);
		q = (mag << 16) / d;
		return (v < 0) ? 48'(-q) : 48'(q);
	endfunction

	function automatic int trimmed_mean(int vals[BATCH_SIZE_DEF]);
		int     tmp;
		longint sum;
		sum = 0;
		for (int i = 0; i < BATCH_SIZE_DEF; i++)
			for (int j = 0; j < BATCH_SIZE_DEF - 1 - i; j++)
				if (vals[j] > vals[j+1]) begin
					tmp = vals[j];
					vals[j] = vals[j+1];
					vals[j+1] = tmp;
				end
		for (int i = 2; i < BATCH_SIZE_DEF - 2; i++)
			sum += vals[i];
		return int'(sum / longint'(BATCH_SIZE_DEF - 4));
	endfunction

	task automatic predict_beat(bit cmd, bit down, bit [15:0] cval);
		bit [31:0]       total;
		longint          delta, y;
		longint unsigned mag, spd, period, cpr, ratio, q;
		speed_report_t   r;
		if (cmd == CMD_OVF) begin
			ovf_cnt = down ? ovf_cnt - 1 : ovf_cnt + 1;
			return;
		end
		total = {16'd0, cval} + (ovf_cnt << 16);
		if (tick_cnt == period_r) begin
			period = (period_r == 0) ? 256 : period_r;
			cpr = (cpr_r == 0) ? 1 : cpr_r;
			ratio = (ratio_r == 0) ? 1 : ratio_r;
			delta = longint'(signed'(total - last_total));
			mag = (delta < 0) ? longint'(-delta) : longint'(delta);
			if (mag >= glitch_r) begin
				delta = 0;
				mag = 0;
			end
			pos_sum = pos_sum + 48'(delta);
			spd = (mag * ((1000 / period) * 60) * 65536) / cpr;
			if (delta < 0)
				speeds[fill] = (spd >= 64'h8000_0000) ? S32_MIN : -int'(spd);
			else
				speeds[fill] = (spd > 64'h7FFF_FFFF) ? S32_MAX : int'(spd);
			fill++;
			last_total = total;
			if (fill >= BATCH_SIZE_DEF) begin
				q = (coeff_r > Q_ONE) ? Q_ONE : coeff_r;
				y = longint'(q) * trimmed_mean(speeds)
					+ longint'(65536 - q) * filt;
				filt = int'(y / 65536);
				r.motor_rpm = filt;
				r.shaft_speed = filt / int'(ratio);
				r.rotor_pos = pos_sum;
				r.shaft_pos = q16_quot(signed'(pos_sum), ratio);
				r.rotor_turns = q16_quot(signed'(pos_sum), cpr);
				r.shaft_turns = q16_quot(signed'(pos_sum), cpr * ratio);
				report_q.push_back(r);
				fill = 0;
			end
			tick_cnt = 0;
		end
		tick_cnt = tick_cnt + 1;
	endtask

	task automatic check_field(string name, bit [47:0] want, bit [47:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		speed_report_t e;
		if (!arst_n) begin
			period_r = PERIOD_RST;
			cpr_r = CPR_RST;
			ratio_r = RATIO_RST;
			glitch_r = GLITCH_RST;
			coeff_r = COEFF_RST;
			ovf_cnt = 0;
			tick_cnt = 0;
			last_total = 0;
			pos_sum = 0;
			fill = 0;
			filt = 0;
			report_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PERIOD: period_r = cfg_data[7:0];
					CFG_CPR:    cpr_r = cfg_data[15:0];
					CFG_RATIO:  ratio_r = cfg_data[9:0];
					CFG_GLITCH: glitch_r = cfg_data[15:0];
					CFG_COEFF:  coeff_r = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_beat(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[16:1]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (report_q.size() == 0) begin
					$display("%0t: unexpected result beat, actual %h", $time, m_axis_tdata);
					fail_count++;
				end else begin
					e = report_q.pop_front();
					check_field("motor_rpm", e.motor_rpm, m_axis_tdata[31:0]);
					check_field("shaft_speed", e.shaft_speed, m_axis_tdata[63:32]);
					check_field("motor_count", e.rotor_pos, m_axis_tdata[111:64]);
					check_field("shaft_position", e.shaft_pos, m_axis_tdata[159:112]);
					check_field("rotor_turns", e.rotor_turns, m_axis_tdata[207:160]);
					check_field("shaft_turns", e.shaft_turns, m_axis_tdata[255:208]);
				end
			end
			pending <= report_q.size();
		end
	end

endmodule

// ===== tb/encoder_speed_estimator_top_test.sv =====
`timescale 1ns / 100ps

module encoder_speed_estimator_top_test;
	import esp_pkg::*;

	// worst case per item is a batch-ending tick plus output stalls; this
	// leaves plenty of room on top of the hold-off and drains
	localparam int CYCLE_LIMIT = 4000000;
	localparam int DRAIN_CYCLES = 600;
	localparam int ITEMS_PER_SET = 240;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// [0] count_down, [16:1] counter_value, [23:17] zero
	logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
	// [0] cmd
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [31:0] motor_rpm, [63:32] shaft_speed, [111:64] motor_count,
	// [159:112] shaft_position, [207:160] rotor_turns, [255:208] shaft_turns
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IW-1:0]      cfg_index = '0;
	logic [CFG_DW-1:0]      cfg_data = '0;

	int fail_count;
	int pending;

	// idle percentages, changed as the run moves through its idling phases
	int send_idle_pct = 35;
	int recv_idle_pct = 61;

	// long output hold-off, requested by toggling hold_req
	bit hold_req = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;

	int cycles = 0;

	// encoder walk: absolute position and the overflow count sent so far
	int enc_pos = 0;
	int ovf_sent = 0;
	int walk_vel = 0;
	int beats_sent = 0;

	always #4 clk = ~clk;

	encoder_speed_estimator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	encoder_speed_estimator_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	// output side: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 4000;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// one input beat; tvalid stays high into the next beat unless a gap falls
	task automatic send_beat(bit cmd, bit down, bit [15:0] cval);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {7'd0, cval, down};
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
		// idling phases by progress through the run
		if (beats_sent == 600) begin
			send_idle_pct = 61;
			recv_idle_pct = 35;
		end else if (beats_sent == 1200) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	// cfg_valid stays high across back-to-back writes
	task automatic write_reg(cfg_idx_t idx, bit [16:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// let the block finish everything it has, including a tick without result
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_set(bit [7:0] per, bit [15:0] cpr, bit [9:0] ratio,
			bit [15:0] glitch, bit [16:0] coeff);
		write_reg(CFG_PERIOD, per);
		write_reg(CFG_CPR, cpr);
		write_reg(CFG_RATIO, ratio);
		write_reg(CFG_GLITCH, glitch);
		write_reg(CFG_COEFF, coeff);
		cfg_valid <= 1'b0;
	endtask

	// move the encoder, sending overflow beats as the 16-bit counter wraps
	task automatic walk_tick(int step);
		enc_pos += step;
		while (ovf_sent < (enc_pos >>> 16)) begin
			send_beat(CMD_OVF, 1'b0, 16'($urandom));
			ovf_sent++;
		end
		while (ovf_sent > (enc_pos >>> 16)) begin
			send_beat(CMD_OVF, 1'b1, 16'($urandom));
			ovf_sent--;
		end
		send_beat(CMD_TICK, 1'($urandom), enc_pos[15:0]);
	endtask

	task automatic random_run(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (i % 40 == 0)
				walk_vel = $signed($urandom_range(0, 1200)) - 600;
			if (r < 75) begin
				// smooth motion with jitter
				walk_tick(walk_vel + $signed($urandom_range(0, 20)) - 10);
			end else if (r < 82) begin
				// big jump, likely a glitch
				walk_tick($signed($urandom_range(0, 400000)) - 200000);
			end else if (r < 90) begin
				send_beat(CMD_TICK, 1'($urandom), 16'($urandom));
			end else begin
				r = $urandom_range(1);
				send_beat(CMD_OVF, r[0], 16'($urandom));
				ovf_sent += r[0] ? -1 : 1;
				enc_pos += r[0] ? -65536 : 65536;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: compute on every tick, no filtering lag, unit scaling
		load_set(8'd1, 16'd1, 10'd1, 16'd65535, Q_ONE);
		send_beat(CMD_OVF, 1'b0, 16'h0000);
		send_beat(CMD_OVF, 1'b1, 16'hFFFF);
		send_beat(CMD_OVF, 1'b1, 16'h0000);    // overflow count goes negative
		send_beat(CMD_TICK, 1'b0, 16'h0000);
		send_beat(CMD_TICK, 1'b1, 16'hFFFF);
		send_beat(CMD_TICK, 1'b0, 16'h0000);   // backward step of 65535, zeroed as glitch
		send_beat(CMD_TICK, 1'b0, 16'h0001);   // small forward, saturates rpm
		send_beat(CMD_TICK, 1'b0, 16'h8000);
		send_beat(CMD_TICK, 1'b0, 16'h0000);
		send_beat(CMD_OVF, 1'b0, 16'h0000);
		send_beat(CMD_OVF, 1'b0, 16'h0000);
		send_beat(CMD_TICK, 1'b0, 16'h0000);   // jump of 2^17, zeroed as glitch
		send_beat(CMD_TICK, 1'b1, 16'hFFFE);
		send_beat(CMD_TICK, 1'b0, 16'h5555);
		send_beat(CMD_TICK, 1'b1, 16'hAAAA);
		send_beat(CMD_TICK, 1'b0, 16'h7FFF);
		send_beat(CMD_TICK, 1'b0, 16'h7FFF);   // zero delta
		send_beat(CMD_TICK, 1'b0, 16'h0000);
		send_beat(CMD_TICK, 1'b0, 16'hFFFF);
		send_beat(CMD_TICK, 1'b0, 16'h1234);
		send_beat(CMD_TICK, 1'b0, 16'h4321);
		send_beat(CMD_TICK, 1'b0, 16'hFFFF);
		drain;
		// resync the walk with the block's overflow count (+1-1-1+1+1 = 1)
		ovf_sent = 1;
		enc_pos = 32'h0001_FFFF;

		// random part over several register settings, extremes included
		load_set(8'd1, 16'd4096, 10'd7, 16'd30000, 17'd32768);
		random_run(ITEMS_PER_SET / 2);
		hold_req <= ~hold_req;                  // receiver holds off a long while
		random_run(ITEMS_PER_SET / 2);
		drain;

		load_set(8'd2, 16'd2000, 10'd30, 16'd60000, 17'd58982);
		random_run(ITEMS_PER_SET / 2);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0); // pause until all results are in
		random_run(ITEMS_PER_SET / 2);
		drain;

		load_set(8'd3, 16'd0, 10'd0, 16'd0, 17'h1FFFF);
		random_run(ITEMS_PER_SET);
		drain;

		load_set(8'd255, 16'd65535, 10'd1000, 16'd1, 17'd0);
		random_run(ITEMS_PER_SET);
		drain;

		// tick counter now above the period: it wraps before matching again
		load_set(8'd0, 16'd100, 10'd1000, 16'd65535, 17'd1);
		random_run(ITEMS_PER_SET / 2);
		drain;

		load_set(8'd1, 16'd1, 10'd3, 16'd65535, 17'd65535);
		random_run(ITEMS_PER_SET);
		drain;

		load_set(8'd5, 16'd500, 10'd12, 16'd40000, 17'd45000);
		random_run(ITEMS_PER_SET);
		drain;

		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== encoder_speed_estimator_top.f =====
+incdir+hw/rtl
hw/rtl/esp_pkg.sv
hw/rtl/esp_div.sv
hw/rtl/esp_dp.sv
hw/rtl/esp_ctrl.sv
hw/rtl/encoder_speed_estimator_top.sv
tb/encoder_speed_estimator_checker.sv
tb/encoder_speed_estimator_top_test.sv
